FILE: design/sem_pkg.sv
// sem_pkg: types, field widths and constants of the sobel edge magnitude block
// also holds one iteration of the integer square root
// no dependencies
package sem_pkg;

    localparam int PIX_W          = 8;
    localparam int CFG_W          = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;
    localparam int MIN_SIZE       = 3;

    localparam int GRAD_W         = 11;   // |gx|, |gy| <= 1020
    localparam int SQ_W           = 20;   // gx*gx <= 1040400
    localparam int SUM_W          = 21;
    localparam int SQRT_W         = 22;
    localparam int SQRT_ITERS     = 11;   // leading bit 4**10 covers a 21-bit sum
    localparam int SQRT_PER_STAGE = 2;
    localparam int SQRT_STAGES    = (SQRT_ITERS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;
    localparam int MAG_CLAMP      = 255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } t_cfg_reg;

    // one line buffer entry: the pixel two rows up and the pixel one row up
    typedef struct packed {
        logic [PIX_W-1:0] two_above;
        logic [PIX_W-1:0] above;
    } t_line;

    typedef struct packed {
        logic [SQRT_W-1:0] rem;
        logic [SQRT_W-1:0] root;
    } t_sqrt;

    function automatic t_sqrt sqrt_step(input t_sqrt s, input int it);
        logic [SQRT_W-1:0] b;
        logic [SQRT_W-1:0] t;
        t_sqrt             r;
        b = SQRT_W'(1) << (2 * (SQRT_ITERS - 1 - it));
        t = s.root + b;
        if (s.rem >= t) begin
            r.rem  = s.rem - t;
            r.root = (s.root >> 1) + b;
        end else begin
            r.rem  = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

endpackage

FILE: design/sobel_edge_magnitude.sv
// sobel_edge_magnitude: streaming 3x3 sobel gradient magnitude over raster gray pixels
// line buffers in one synchronous memory, pipelined integer square root; uses sem_pkg
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid/s_axis_tready    tdata gray_pixel, tuser start_of_frame
//  m_axis    out        m_axis_tvalid/m_axis_tready    tdata edge_magnitude, tuser interior_valid
//  cfg       in         i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data
//
//  one pixel per cycle unless the output stalls; a result passes line buffer read, gradient,
//  squares, sum, six square root stages of up to two iterations, output register
//  reset clears position counters, window taps and stage valid bits and loads the size
//  registers with 640 x 480; the line buffer memory is not cleared
//  each stage moves on when the next one is empty or moving, so input ready drops only
//  when every stage holds a result and the output is stalled
module sobel_edge_magnitude
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIX_W-1:0]     s_axis_tdata,   // [7:0] gray_pixel
    input  logic                 s_axis_tuser,   // [0] start_of_frame
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [PIX_W-1:0]     m_axis_tdata,   // [7:0] edge_magnitude
    output logic                 m_axis_tuser,   // [0] interior_valid
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int XW  = (WW > CFG_W) ? WW : CFG_W;
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int YW  = (HW > CFG_W) ? HW : CFG_W;
    localparam int SQ0 = 4;
    localparam int NST = SQ0 + SQRT_STAGES + 1;
    localparam int OUT = NST - 1;

    // size registers
    logic [CFG_W-1:0] r_width, r_height;
    logic [XW-1:0]    w_wx;
    logic [YW-1:0]    w_hx;
    logic [WW-1:0]    w_w;
    logic [HW-1:0]    w_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(RESET_WIDTH);
            r_height <= CFG_W'(RESET_HEIGHT);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_wx = XW'(r_width);
        w_hx = YW'(r_height);
        if (w_wx < XW'(MIN_SIZE))       w_w = WW'(MIN_SIZE);
        else if (w_wx > XW'(MAX_WIDTH)) w_w = WW'(MAX_WIDTH);
        else                            w_w = w_wx[WW-1:0];
        if (w_hx < YW'(MIN_SIZE))        w_h = HW'(MIN_SIZE);
        else if (w_hx > YW'(MAX_HEIGHT)) w_h = HW'(MAX_HEIGHT);
        else                             w_h = w_hx[HW-1:0];
    end

    // stage flow control
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_take;
    logic [NST-1:0] w_ld;

    always_comb begin
        w_take[OUT] = !r_vld[OUT] || m_axis_tready;
        for (int k = OUT - 1; k >= 0; k--) begin
            w_take[k] = !r_vld[k] || w_take[k+1];
        end
        w_ld[0] = s_axis_tvalid && w_take[0];
        for (int k = 1; k < NST; k++) begin
            w_ld[k] = r_vld[k-1] && w_take[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= w_ld | (r_vld & ~w_take);
        end
    end

    assign s_axis_tready = w_take[0];

    // position of the incoming pixel
    logic [CW-1:0] r_col_cnt, n_col_cnt, w_col_c, w_col;
    logic [RW-1:0] r_row_cnt, n_row_cnt, w_row_c, w_row;
    logic [HW-1:0] w_row_t, w_row_inc;
    logic [WW-1:0] w_col_inc;
    logic          w_interior;

    always_comb begin
        w_col_c = s_axis_tuser ? '0 : r_col_cnt;
        w_row_c = s_axis_tuser ? '0 : r_row_cnt;
        w_col   = w_col_c;
        w_row_t = HW'(w_row_c);
        // a width shrunk mid-frame can leave the column past the row end
        if (WW'(w_col_c) >= w_w) begin
            w_col   = '0;
            w_row_t = HW'(w_row_c) + HW'(1);
        end
        if (w_row_t >= w_h) w_row = '0;
        else                w_row = w_row_t[RW-1:0];

        w_col_inc = WW'(w_col) + WW'(1);
        w_row_inc = HW'(w_row) + HW'(1);
        if (w_col_inc >= w_w) begin
            n_col_cnt = '0;
            n_row_cnt = (w_row_inc >= w_h) ? '0 : w_row_inc[RW-1:0];
        end else begin
            n_col_cnt = w_col_inc[CW-1:0];
            n_row_cnt = w_row;
        end
        w_interior = (w_col >= CW'(2)) && (w_row >= RW'(2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (w_ld[0]) begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
        end
    end

    // line buffer memory and stage 0
    t_line            r_lbuf [MAX_WIDTH];
    t_line            r_rd, r_fwd_data, w_line0, w_wr;
    logic             r_fwd;
    logic [PIX_W-1:0] r_pix0;
    logic [CW-1:0]    r_col0;
    logic             r_int0;

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_rd <= r_lbuf[w_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[1]) begin
            r_lbuf[r_col0] <= w_wr;
        end
    end

    // a read that meets the write of the same column takes the written value
    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_fwd      <= w_ld[1] && (w_col == r_col0);
            r_fwd_data <= w_wr;
            r_pix0     <= s_axis_tdata;
            r_col0     <= w_col;
            r_int0     <= w_interior;
        end
    end

    always_comb begin
        w_line0        = r_fwd ? r_fwd_data : r_rd;
        w_wr.two_above = w_line0.above;
        w_wr.above     = r_pix0;
    end

    // window taps, row-major with the newest column on the right
    logic [PIX_W-1:0]         r_taps [9];
    logic [PIX_W-1:0]         n_taps [9];
    logic signed [GRAD_W-1:0] w_t [9];
    logic signed [GRAD_W-1:0] w_gx, w_gy;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_taps[i*3]     = r_taps[i*3+1];
            n_taps[i*3 + 1] = r_taps[i*3+2];
        end
        n_taps[2] = w_line0.two_above;
        n_taps[5] = w_line0.above;
        n_taps[8] = r_pix0;
        for (int i = 0; i < 9; i++) begin
            w_t[i] = $signed({{(GRAD_W-PIX_W){1'b0}}, n_taps[i]});
        end
        w_gx = (w_t[2] + (w_t[5] <<< 1) + w_t[8]) - (w_t[0] + (w_t[3] <<< 1) + w_t[6]);
        w_gy = (w_t[6] + (w_t[7] <<< 1) + w_t[8]) - (w_t[0] + (w_t[1] <<< 1) + w_t[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) r_taps[i] <= '0;
        end else if (w_ld[1]) begin
            r_taps <= n_taps;
        end
    end

    // gradient, squares and sum
    logic signed [GRAD_W-1:0]   r_gx, r_gy;
    logic signed [2*GRAD_W-1:0] w_px, w_py;
    logic [SQ_W-1:0]            r_sqx, r_sqy;
    logic [SUM_W-1:0]           r_sum;
    logic                       r_int1, r_int2, r_int3;

    assign w_px = r_gx * r_gx;
    assign w_py = r_gy * r_gy;

    always_ff @(posedge i_clk) begin
        if (w_ld[1]) begin
            r_gx   <= w_gx;
            r_gy   <= w_gy;
            r_int1 <= r_int0;
        end
        if (w_ld[2]) begin
            r_sqx  <= w_px[SQ_W-1:0];
            r_sqy  <= w_py[SQ_W-1:0];
            r_int2 <= r_int1;
        end
        if (w_ld[3]) begin
            r_sum  <= SUM_W'(r_sqx) + SUM_W'(r_sqy);
            r_int3 <= r_int2;
        end
    end

    // square root pipeline
    t_sqrt r_sq     [SQRT_STAGES];
    logic  r_sq_int [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
        t_sqrt w_in, w_out;
        logic  w_in_int;

        if (k == 0) begin : g_first
            always_comb begin
                w_in.rem  = SQRT_W'(r_sum);
                w_in.root = '0;
                w_in_int  = r_int3;
            end
        end else begin : g_next
            always_comb begin
                w_in     = r_sq[k-1];
                w_in_int = r_sq_int[k-1];
            end
        end

        always_comb begin
            w_out = w_in;
            for (int j = 0; j < SQRT_PER_STAGE; j++) begin
                if (k * SQRT_PER_STAGE + j < SQRT_ITERS) begin
                    w_out = sqrt_step(w_out, k * SQRT_PER_STAGE + j);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ld[SQ0+k]) begin
                r_sq[k]     <= w_out;
                r_sq_int[k] <= w_in_int;
            end
        end
    end

    // output register
    logic [SQRT_W-1:0] w_root;
    logic [PIX_W-1:0]  w_mag;
    logic [PIX_W-1:0]  r_mag;
    logic              r_int_out;

    always_comb begin
        w_root = r_sq[SQRT_STAGES-1].root;
        if (!r_sq_int[SQRT_STAGES-1])             w_mag = '0;
        else if (w_root > SQRT_W'(MAG_CLAMP))     w_mag = PIX_W'(MAG_CLAMP);
        else                                      w_mag = w_root[PIX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[OUT]) begin
            r_mag     <= w_mag;
            r_int_out <= r_sq_int[SQRT_STAGES-1];
        end
    end

    assign m_axis_tvalid = r_vld[OUT];
    assign m_axis_tdata  = r_mag;
    assign m_axis_tuser  = r_int_out;

    // border results carry zero magnitude
    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("border result with nonzero magnitude");

    // input only backs up when the whole pipeline is full and the output stalls
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&r_vld) && !m_axis_tready)
        else $error("input stalled with room in the pipeline");

    // a frame start lands at column zero and is never interior
    a_sof_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ld[0] && s_axis_tuser |=> r_col0 == '0 && !r_int0)
        else $error("frame start not at column zero");

    // the stored column stays inside the row when the width is unchanged
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ld[0] && !i_cfg_valid |=> WW'(r_col_cnt) < w_w)
        else $error("column counter past row end");

endmodule
